FILE: sv/lfpd_pkg.sv
`default_nettype none
package lfpd_pkg;

  localparam int unsigned SensorCount = 10;
  localparam int unsigned SampleW     = 12;
  localparam int unsigned IdxW        = 4;

  localparam logic [IdxW-1:0] RegThreshold = 4'd0;
  localparam logic [IdxW-1:0] RegGainPC    = 4'd1;
  localparam logic [IdxW-1:0] RegGainPH    = 4'd2;
  localparam logic [IdxW-1:0] RegGainDC    = 4'd3;
  localparam logic [IdxW-1:0] RegGainDH    = 4'd4;
  localparam logic [IdxW-1:0] RegCruise    = 4'd5;
  localparam logic [IdxW-1:0] RegCurve     = 4'd6;
  localparam logic [IdxW-1:0] RegPivot     = 4'd7;

  localparam logic [1:0] ModeForward = 2'd0;
  localparam logic [1:0] ModeLeft    = 2'd1;
  localparam logic [1:0] ModeRight   = 2'd2;

  typedef enum logic [7:0] {
    StIdle   = 8'b0000_0001,
    StScan   = 8'b0000_0010,
    StDecide = 8'b0000_0100,
    StDiv    = 8'b0000_1000,
    StErr    = 8'b0001_0000,
    StMul    = 8'b0010_0000,
    StFin    = 8'b0100_0000,
    StRes    = 8'b1000_0000
  } state_e;

  function automatic logic signed [11:0] weight_q8(input logic [IdxW-1:0] idx);
    case (idx)
      4'd0:    weight_q8 = -12'sd1536;
      4'd1:    weight_q8 = -12'sd1152;
      4'd2:    weight_q8 = -12'sd768;
      4'd3:    weight_q8 = -12'sd384;
      4'd4:    weight_q8 = -12'sd102;
      4'd5:    weight_q8 = 12'sd102;
      4'd6:    weight_q8 = 12'sd384;
      4'd7:    weight_q8 = 12'sd768;
      4'd8:    weight_q8 = 12'sd1152;
      4'd9:    weight_q8 = 12'sd1536;
      default: weight_q8 = 12'sd0;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: sv/lfpd_div.sv
`default_nettype none
module lfpd_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [11:0] dividend_i,
  input  wire logic [3:0]  divisor_i,
  output logic             done_o,
  output logic [11:0]      quotient_o
);
  import lfpd_pkg::*;

  logic [11:0] num_q;
  logic [11:0] quo_q;
  logic [4:0]  rem_q;
  logic [3:0]  den_q;
  logic [3:0]  cnt_q;
  logic        busy_q;
  logic        done_q;
  logic [5:0]  trial;
  logic [5:0]  diff;

  assign trial = {rem_q, num_q[11]};
  assign diff  = trial - {2'b00, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd11) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      den_q <= divisor_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[10:0], 1'b0};
      if (!diff[5]) begin
        rem_q <= diff[4:0];
        quo_q <= {quo_q[10:0], 1'b1};
      end else begin
        rem_q <= trial[4:0];
        quo_q <= {quo_q[10:0], 1'b0};
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

FILE: sv/line_follower_pd_steering.sv
`default_nettype none
// Channel  Direction  Handshake                  Word
// in       input      in_valid_i / in_stall_o    sample_0_i .. sample_9_i
// out      output     out_valid_o / out_stall_i  drive_mode_o, duty_a_o, duty_b_o
// cfg      input      cfg_we_i                   cfg_idx_i, cfg_wdata_i
// A PD frame passes, once accepted, through the scan of the ten samples, a
// decision step, the restoring divider, an error step, four multiplier passes,
// a finish step and the load into the result register.
// Other frames go from the decision straight to the load. The input stays stalled
// until the load, and a frame waits in its last state while a stalled word is held.
// Reset restores the register defaults and clears the steering state.
module line_follower_pd_steering (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [11:0] sample_0_i,
  input  wire logic [11:0] sample_1_i,
  input  wire logic [11:0] sample_2_i,
  input  wire logic [11:0] sample_3_i,
  input  wire logic [11:0] sample_4_i,
  input  wire logic [11:0] sample_5_i,
  input  wire logic [11:0] sample_6_i,
  input  wire logic [11:0] sample_7_i,
  input  wire logic [11:0] sample_8_i,
  input  wire logic [11:0] sample_9_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       drive_mode_o,
  output logic [7:0]       duty_a_o,
  output logic [7:0]       duty_b_o,
  input  wire logic        cfg_we_i,
  input  wire logic [lfpd_pkg::IdxW-1:0] cfg_idx_i,
  input  wire logic [11:0] cfg_wdata_i
);
  import lfpd_pkg::*;

  state_e state_q;

  logic [11:0] thr_q, kpc_q, kph_q, kdc_q, kdh_q;
  logic [7:0]  cruise_q, curve_q, pivot_q;

  logic signed [11:0] prev_err_q;
  logic signed [8:0]  sm_q;
  logic signed [15:0] prev_corr_q;
  logic        seen_left_q;
  logic [7:0]  seen_cnt_q;
  logic [1:0]  conf_q;
  logic [2:0]  hold_q;
  logic        acute_left_q;
  logic [7:0]  duty_a_q, duty_b_q;
  logic [1:0]  mode_q;

  logic [SampleW-1:0] samp_q [SensorCount];
  logic [IdxW-1:0] idx_q;
  logic signed [13:0] pos_sum_q;
  logic [3:0]  active_q;
  logic        left_q, center_q, right_q, ext_left_q, ext_right_q, inner_right_q;

  logic signed [11:0] err_q;
  logic signed [12:0] d_q;
  logic        hard_q;
  logic [1:0]  step_q;
  logic signed [27:0] acc_q;

  logic        out_valid_q;
  logic [1:0]  out_mode_q;
  logic [7:0]  out_a_q, out_b_q;

  // Sensor scan.
  logic        on;
  logic [7:0]  cnt_inc;
  assign on      = samp_q[idx_q] > thr_q;
  assign cnt_inc = (seen_cnt_q == 8'd255) ? seen_cnt_q : seen_cnt_q + 8'd1;

  // Decision after the scan.
  logic [7:0]  cnt_n;
  logic [1:0]  conf_a, conf_n;
  logic        acl_n;
  logic [2:0]  hold_n;
  logic [8:0]  sp_sum;
  logic [7:0]  sp_acute;
  logic [10:0] rec_sum;
  logic [7:0]  rec;

  always_comb begin
    cnt_n = (active_q == 4'd0 && seen_cnt_q != 8'd0) ? seen_cnt_q - 8'd1 : seen_cnt_q;
    conf_a = conf_q;
    acl_n  = acute_left_q;
    if (!center_q && active_q <= 4'd3) begin
      if (left_q && !right_q) begin
        conf_a = conf_q + 2'd1;
        acl_n  = 1'b1;
      end else if (right_q && !left_q) begin
        conf_a = conf_q + 2'd1;
        acl_n  = 1'b0;
      end
    end else begin
      conf_a = 2'd0;
    end
    conf_n = conf_a;
    hold_n = hold_q;
    if (conf_a >= 2'd2) begin
      hold_n = 3'd6;
      conf_n = 2'd0;
    end
    sp_sum   = {1'b0, pivot_q} + 9'd10;
    sp_acute = sp_sum[8] ? 8'd255 : sp_sum[7:0];
    rec_sum  = 11'd60 + {3'b000, cnt_n} * 11'd6;
    rec      = (rec_sum > 11'd255) ? 8'd255 : rec_sum[7:0];
  end

  // Divider.
  logic        div_start, div_done;
  logic [11:0] div_quo;
  logic [13:0] sum_abs;
  assign sum_abs   = pos_sum_q[13] ? -pos_sum_q : pos_sum_q;
  assign div_start = (state_q == StDecide) && (hold_n == 3'd0) && (active_q != 4'd0)
                     && !(ext_left_q && ext_right_q && center_q)
                     && !(ext_right_q || inner_right_q) && center_q;

  lfpd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_abs[11:0]),
    .divisor_i  (active_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  logic signed [11:0] err_raw, err_dz;
  assign err_raw = pos_sum_q[13] ? -$signed(div_quo) : $signed(div_quo);
  assign err_dz  = (err_raw > -12'sd31 && err_raw < 12'sd31) ? 12'sd0 : err_raw;

  logic [10:0] aerr_dz, aerr;
  assign aerr_dz = err_dz[11] ? 11'(-err_dz) : 11'(err_dz);
  assign aerr    = err_q[11] ? 11'(-err_q) : 11'(err_q);

  // Shared multiplier.
  logic signed [12:0] mul_a;
  logic signed [13:0] mul_b;
  logic signed [26:0] prod;
  logic signed [27:0] acc_sum;
  logic signed [19:0] sm_raw;
  logic signed [8:0]  sm_new;

  always_comb begin
    case (step_q)
      2'd0: begin
        mul_a = 13'sd179;
        mul_b = 14'(sm_q);
      end
      2'd1: begin
        mul_a = 13'sd77;
        mul_b = 14'(d_q);
      end
      2'd2: begin
        mul_a = $signed({1'b0, hard_q ? kph_q : kpc_q});
        mul_b = 14'(err_q);
      end
      default: begin
        mul_a = $signed({1'b0, hard_q ? kdh_q : kdc_q});
        mul_b = 14'(sm_q);
      end
    endcase
    prod    = mul_a * mul_b;
    acc_sum = acc_q + 28'(prod);
    sm_raw  = acc_sum[27:8];
    if (sm_raw > 20'sd154) begin
      sm_new = 9'sd154;
    end else if (sm_raw < -20'sd154) begin
      sm_new = -9'sd154;
    end else begin
      sm_new = sm_raw[8:0];
    end
  end

  // Correction and duties.
  logic signed [11:0] corr0;
  logic signed [16:0] lo, hi, c1;
  logic signed [15:0] c2;
  logic [8:0]  e;
  logic [15:0] boost_p;
  logic [6:0]  boost;
  logic signed [17:0] c3;
  logic signed [9:0]  c4;
  logic [7:0]  speed;
  logic signed [10:0] da, db;
  logic [7:0]  duty_a_n, duty_b_n;

  always_comb begin
    corr0 = acc_q[27:16];
    lo = 17'(prev_corr_q) - 17'sd30;
    hi = 17'(prev_corr_q) + 17'sd30;
    if (17'(corr0) < lo) begin
      c1 = lo;
    end else if (17'(corr0) > hi) begin
      c1 = hi;
    end else begin
      c1 = 17'(corr0);
    end
    if (c1 > 17'sd32767) begin
      c2 = 16'sh7fff;
    end else if (c1 < -17'sd32768) begin
      c2 = 16'sh8000;
    end else begin
      c2 = c1[15:0];
    end
    e       = (aerr > 11'd256) ? 9'd256 : aerr[8:0];
    boost_p = 16'd80 * {7'd0, e} + 16'd128;
    boost   = boost_p[14:8];
    c3 = 18'(c2);
    if (aerr >= 11'd103) begin
      c3 = (c2 > 16'sd0) ? 18'(c2) + 18'(boost) : 18'(c2) - 18'(boost);
    end
    if (c3 > 18'sd255) begin
      c4 = 10'sd255;
    end else if (c3 < -18'sd255) begin
      c4 = -10'sd255;
    end else begin
      c4 = c3[9:0];
    end
    speed = hard_q ? curve_q : cruise_q;
    da = $signed({3'b000, speed}) - 11'(c4);
    db = $signed({3'b000, speed}) + 11'(c4);
    duty_a_n = (da < 11'sd85) ? 8'd85 : ((da > 11'sd255) ? 8'd255 : da[7:0]);
    duty_b_n = (db < 11'sd85) ? 8'd85 : ((db > 11'sd255) ? 8'd255 : db[7:0]);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      samp_q[0] <= sample_0_i;
      samp_q[1] <= sample_1_i;
      samp_q[2] <= sample_2_i;
      samp_q[3] <= sample_3_i;
      samp_q[4] <= sample_4_i;
      samp_q[5] <= sample_5_i;
      samp_q[6] <= sample_6_i;
      samp_q[7] <= sample_7_i;
      samp_q[8] <= sample_8_i;
      samp_q[9] <= sample_9_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      thr_q        <= 12'd4050;
      kpc_q        <= 12'd128;
      kph_q        <= 12'd256;
      kdc_q        <= 12'd410;
      kdh_q        <= 12'd870;
      cruise_q     <= 8'd180;
      curve_q      <= 8'd150;
      pivot_q      <= 8'd245;
      prev_err_q   <= '0;
      sm_q         <= '0;
      prev_corr_q  <= '0;
      seen_left_q  <= 1'b0;
      seen_cnt_q   <= '0;
      conf_q       <= '0;
      hold_q       <= '0;
      acute_left_q <= 1'b0;
      duty_a_q     <= '0;
      duty_b_q     <= '0;
      mode_q       <= ModeForward;
      idx_q        <= '0;
      pos_sum_q    <= '0;
      active_q     <= '0;
      left_q       <= 1'b0;
      center_q     <= 1'b0;
      right_q      <= 1'b0;
      ext_left_q   <= 1'b0;
      ext_right_q  <= 1'b0;
      inner_right_q <= 1'b0;
      err_q        <= '0;
      d_q          <= '0;
      hard_q       <= 1'b0;
      step_q       <= '0;
      acc_q        <= '0;
      out_valid_q  <= 1'b0;
      out_mode_q   <= ModeForward;
      out_a_q      <= '0;
      out_b_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegThreshold: thr_q    <= cfg_wdata_i;
          RegGainPC:    kpc_q    <= cfg_wdata_i;
          RegGainPH:    kph_q    <= cfg_wdata_i;
          RegGainDC:    kdc_q    <= cfg_wdata_i;
          RegGainDH:    kdh_q    <= cfg_wdata_i;
          RegCruise:    cruise_q <= cfg_wdata_i[7:0];
          RegCurve:     curve_q  <= cfg_wdata_i[7:0];
          RegPivot:     pivot_q  <= cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (state_q == StRes && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            idx_q         <= '0;
            pos_sum_q     <= '0;
            active_q      <= '0;
            left_q        <= 1'b0;
            center_q      <= 1'b0;
            right_q       <= 1'b0;
            ext_left_q    <= 1'b0;
            ext_right_q   <= 1'b0;
            inner_right_q <= 1'b0;
            state_q       <= StScan;
          end
        end
        StScan: begin
          if (on) begin
            pos_sum_q <= pos_sum_q + 14'(weight_q8(idx_q));
            active_q  <= active_q + 4'd1;
            if (idx_q == 4'd4 || idx_q == 4'd5) begin
              center_q <= 1'b1;
            end else if (idx_q <= 4'd3) begin
              left_q      <= 1'b1;
              seen_left_q <= 1'b1;
              seen_cnt_q  <= cnt_inc;
              if (idx_q <= 4'd1) begin
                ext_left_q <= 1'b1;
              end
            end else begin
              right_q     <= 1'b1;
              seen_left_q <= 1'b0;
              seen_cnt_q  <= cnt_inc;
              if (idx_q >= 4'd8) begin
                ext_right_q <= 1'b1;
              end else begin
                inner_right_q <= 1'b1;
              end
            end
          end
          if (idx_q == IdxW'(SensorCount - 1)) begin
            state_q <= StDecide;
          end else begin
            idx_q <= idx_q + 4'd1;
          end
        end
        StDecide: begin
          seen_cnt_q   <= cnt_n;
          conf_q       <= conf_n;
          acute_left_q <= acl_n;
          state_q      <= div_start ? StDiv : StRes;
          if (hold_n != 3'd0) begin
            duty_a_q <= sp_acute;
            duty_b_q <= sp_acute;
            if (center_q) begin
              hold_q      <= 3'd0;
              prev_err_q  <= '0;
              sm_q        <= '0;
              prev_corr_q <= '0;
              mode_q      <= ModeForward;
            end else begin
              hold_q <= hold_n - 3'd1;
              mode_q <= acl_n ? ModeLeft : ModeRight;
            end
          end else begin
            hold_q <= hold_n;
            if (active_q == 4'd0) begin
              duty_a_q <= rec;
              duty_b_q <= rec;
              mode_q   <= seen_left_q ? ModeLeft : ModeRight;
            end else if (ext_left_q && ext_right_q && center_q) begin
              mode_q <= ModeForward;
            end else if (ext_right_q || inner_right_q) begin
              prev_err_q  <= '0;
              sm_q        <= '0;
              prev_corr_q <= '0;
              duty_a_q    <= pivot_q;
              duty_b_q    <= pivot_q;
              mode_q      <= ModeRight;
            end else if (!center_q) begin
              duty_a_q <= 8'd150;
              duty_b_q <= 8'd150;
              mode_q   <= ModeForward;
            end
          end
        end
        StDiv: begin
          if (div_done) begin
            state_q <= StErr;
          end
        end
        StErr: begin
          err_q      <= err_dz;
          d_q        <= 13'(err_dz) - 13'(prev_err_q);
          prev_err_q <= err_dz;
          hard_q     <= aerr_dz >= 11'd180;
          step_q     <= 2'd0;
          state_q    <= StMul;
        end
        StMul: begin
          step_q <= step_q + 2'd1;
          case (step_q)
            2'd0: acc_q <= 28'(prod) + 28'sd128;
            2'd1: sm_q  <= sm_new;
            2'd2: acc_q <= 28'(prod) + 28'sd32768;
            default: begin
              acc_q   <= acc_sum;
              state_q <= StFin;
            end
          endcase
        end
        StFin: begin
          prev_corr_q <= c2;
          duty_a_q    <= duty_a_n;
          duty_b_q    <= duty_b_n;
          mode_q      <= ModeForward;
          state_q     <= StRes;
        end
        StRes: begin
          if (!out_valid_q || !out_stall_i) begin
            out_mode_q  <= mode_q;
            out_a_q     <= duty_a_q;
            out_b_q     <= duty_b_q;
            state_q     <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o   = (state_q != StIdle);
  assign out_valid_o  = out_valid_q;
  assign drive_mode_o = out_mode_q;
  assign duty_a_o     = out_a_q;
  assign duty_b_o     = out_b_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block took a word and stayed ready");
  a_sm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sm_q >= -9'sd154) && (sm_q <= 9'sd154))
    else $error("smoothed derivative out of range");
  a_hold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q <= 3'd5)
    else $error("acute hold out of range");
  a_mode_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (drive_mode_o == ModeForward || drive_mode_o == ModeLeft
                     || drive_mode_o == ModeRight))
    else $error("bad drive mode");
  a_pd_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin) |=> (duty_a_q >= 8'd85 && duty_b_q >= 8'd85))
    else $error("PD duty below floor");

endmodule
`default_nettype wire
